// ===== hdl/arp_pkg.sv =====
// ----------------------------------------------------------------------------
// arp_pkg
// shared types, codes and sizes for the arp receive path and address cache
// ----------------------------------------------------------------------------
package arp_pkg;

	localparam int CACHE_DEPTH = 64;
	localparam int IDX_W = $clog2(CACHE_DEPTH);
	localparam int CNT_W = $clog2(CACHE_DEPTH + 1);

	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [15:0] HW_TYPE_ETH = 16'h0001;
	localparam logic [15:0] PROTO_IPV4 = 16'h0800;
	localparam logic [7:0] HW_LEN_ETH = 8'd6;
	localparam logic [7:0] PROTO_LEN_IPV4 = 8'd4;
	localparam logic [15:0] OPER_REQUEST = 16'd1;
	localparam logic [15:0] OPER_REPLY = 16'd2;

	localparam logic [2:0] ST_UNSUPPORTED = 3'd0;
	localparam logic [2:0] ST_OWN = 3'd1;
	localparam logic [2:0] ST_BAD_OPER = 3'd2;
	localparam logic [2:0] ST_REQUEST = 3'd3;
	localparam logic [2:0] ST_CACHED = 3'd4;
	localparam logic [2:0] ST_HIT = 3'd5;
	localparam logic [2:0] ST_MISS = 3'd6;

	localparam logic CFG_LOCAL_HW = 1'b0;
	localparam logic CFG_LOCAL_IP_VALID = 1'b1;

	typedef struct packed {
		logic cmd;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0] hw_len;
		logic [7:0] proto_len;
		logic [15:0] oper;
		logic [47:0] sender_hw;
		logic [31:0] sender_ip;
		logic [31:0] query_ip;
	} in_t;

	typedef struct packed {
		logic [2:0] status;
		logic send_reply;
		logic [47:0] reply_dest_hw;
		logic [31:0] reply_target_ip;
		logic lookup_hit;
		logic [47:0] lookup_hw;
	} out_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] hw;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic rotate;
	} chain_ctl_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_WB
	} fsm_t;

endpackage

// ===== hdl/arp_receive_and_cache.sv =====
// ----------------------------------------------------------------------------
// arp_receive_and_cache
// header transaction: registered on accept, moved to out register in writeback
// lookup: writeback after a scan rotating every cell past the tail compare
// one transaction in flight; the output register lets the next be accepted
// async reset clears control, config and entry count; entries need no clear
// ----------------------------------------------------------------------------
module arp_receive_and_cache (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_addr,
	input  logic [47:0]    cfg_wdata,
	input  logic           in_valid,
	output logic           in_ready,
	input  arp_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output arp_pkg::out_t  out_data
);

	arp_pkg::fsm_t state_q, state_d;
	arp_pkg::chain_ctl_t ctl;
	arp_pkg::entry_t new_entry, tail;
	arp_pkg::out_t hdr_res, scan_res, pend_q, out_q;

	logic [47:0] local_hw_q;
	logic local_ip_valid_q;
	logic [arp_pkg::CNT_W-1:0] count_q;
	logic [arp_pkg::IDX_W-1:0] scan_q, pos;
	logic [31:0] query_q;
	logic hit_q;
	logic [47:0] found_hw_q;
	logic out_valid_q;
	logic do_store, cur_match, scan_last, out_load, accept;

	assign accept = in_valid && in_ready;

	// header checks
	always_comb begin
		hdr_res = '0;
		do_store = 1'b0;
		if (in_data.hw_type != arp_pkg::HW_TYPE_ETH || in_data.proto_type != arp_pkg::PROTO_IPV4
				|| in_data.hw_len != arp_pkg::HW_LEN_ETH
				|| in_data.proto_len != arp_pkg::PROTO_LEN_IPV4) begin
			hdr_res.status = arp_pkg::ST_UNSUPPORTED;
		end else if (in_data.sender_hw == local_hw_q) begin
			hdr_res.status = arp_pkg::ST_OWN;
		end else if (in_data.oper == arp_pkg::OPER_REQUEST) begin
			hdr_res.status = arp_pkg::ST_REQUEST;
			if (local_ip_valid_q) begin
				hdr_res.send_reply = 1'b1;
				hdr_res.reply_dest_hw = in_data.sender_hw;
				hdr_res.reply_target_ip = in_data.sender_ip;
			end
		end else if (in_data.oper == arp_pkg::OPER_REPLY) begin
			hdr_res.status = arp_pkg::ST_CACHED;
			do_store = 1'b1;
		end else begin
			hdr_res.status = arp_pkg::ST_BAD_OPER;
		end
	end

	assign new_entry.ip = in_data.sender_ip;
	assign new_entry.hw = in_data.sender_hw;

	arp_chain u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.new_entry (new_entry),
		.tail      (tail)
	);

	// tail holds the entry that sat at position pos before the scan began
	assign pos = arp_pkg::IDX_W'(arp_pkg::CACHE_DEPTH - 1) - scan_q;
	assign cur_match = (arp_pkg::CNT_W'(pos) < count_q) && (tail.ip == query_q);
	assign scan_last = (scan_q == arp_pkg::IDX_W'(arp_pkg::CACHE_DEPTH - 1));

	always_comb begin
		scan_res = '0;
		if (hit_q || cur_match) begin
			scan_res.status = arp_pkg::ST_HIT;
			scan_res.lookup_hit = 1'b1;
			scan_res.lookup_hw = cur_match ? tail.hw : found_hw_q;
		end else begin
			scan_res.status = arp_pkg::ST_MISS;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		ctl = '0;
		out_load = 1'b0;
		case (state_q)
			arp_pkg::FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_data.cmd == arp_pkg::CMD_LOOKUP) begin
						state_d = arp_pkg::FSM_SCAN;
					end else begin
						state_d = arp_pkg::FSM_WB;
						ctl.shift = do_store;
					end
				end
			end
			arp_pkg::FSM_SCAN: begin
				ctl.shift = 1'b1;
				ctl.rotate = 1'b1;
				if (scan_last) begin
					state_d = arp_pkg::FSM_WB;
				end
			end
			arp_pkg::FSM_WB: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = arp_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = arp_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arp_pkg::FSM_IDLE;
			count_q <= '0;
			scan_q <= '0;
			hit_q <= 1'b0;
			out_valid_q <= 1'b0;
			local_hw_q <= '0;
			local_ip_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_addr)
					arp_pkg::CFG_LOCAL_HW: local_hw_q <= cfg_wdata;
					arp_pkg::CFG_LOCAL_IP_VALID: local_ip_valid_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (accept) begin
				scan_q <= '0;
				hit_q <= 1'b0;
				if (in_data.cmd == arp_pkg::CMD_HEADER && do_store
						&& count_q != arp_pkg::CNT_W'(arp_pkg::CACHE_DEPTH)) begin
					count_q <= count_q + 1'b1;
				end
			end else if (state_q == arp_pkg::FSM_SCAN) begin
				scan_q <= scan_q + 1'b1;
				if (cur_match) begin
					hit_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			query_q <= in_data.query_ip;
			pend_q <= hdr_res;
		end else if (state_q == arp_pkg::FSM_SCAN) begin
			if (cur_match) begin
				found_hw_q <= tail.hw;
			end
			if (scan_last) begin
				pend_q <= scan_res;
			end
		end
		if (out_load) begin
			out_q <= pend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// ===== hdl/arp_cell.sv =====
// ----------------------------------------------------------------------------
// arp_cell
// one cache entry; takes its neighbor's entry when the row shifts
// ----------------------------------------------------------------------------
module arp_cell (
	input  logic            clk,
	input  logic            shift,
	input  arp_pkg::entry_t d,
	output arp_pkg::entry_t q
);

	arp_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

// ===== hdl/arp_chain.sv =====
// ----------------------------------------------------------------------------
// arp_chain
// row of cache cells, newest at the head; inserts shift in at the head and
// drop the oldest off the tail, a scan rotates the tail back to the head
// ----------------------------------------------------------------------------
module arp_chain (
	input  logic                clk,
	input  arp_pkg::chain_ctl_t ctl,
	input  arp_pkg::entry_t     new_entry,
	output arp_pkg::entry_t     tail
);

	arp_pkg::entry_t cell_d [arp_pkg::CACHE_DEPTH];
	arp_pkg::entry_t cell_q [arp_pkg::CACHE_DEPTH];

	assign cell_d[0] = ctl.rotate ? cell_q[arp_pkg::CACHE_DEPTH-1] : new_entry;

	genvar i;
	generate
		for (i = 1; i < arp_pkg::CACHE_DEPTH; i++) begin : g_link
			assign cell_d[i] = cell_q[i-1];
		end
		for (i = 0; i < arp_pkg::CACHE_DEPTH; i++) begin : g_cell
			arp_cell u_cell (
				.clk   (clk),
				.shift (ctl.shift),
				.d     (cell_d[i]),
				.q     (cell_q[i])
			);
		end
	endgenerate

	assign tail = cell_q[arp_pkg::CACHE_DEPTH-1];

endmodule
